[rtl/bba_pkg.sv]
// Shared constants, types and helper functions for the bitmap block allocator.
package bba_pkg;

   // Map geometry; WORD_BITS is a power of two so word and bit split by shift
   localparam int MAP_CHUNKS = 8;
   localparam int CHUNK_BITS = 8192;
   localparam int WORD_BITS  = 32;

   localparam int TOTAL_BITS = MAP_CHUNKS * CHUNK_BITS;
   localparam int MAP_WORDS  = (TOTAL_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int LAST_BITS  = TOTAL_BITS - (MAP_WORDS - 1) * WORD_BITS;

   localparam int BIT_W  = $clog2(WORD_BITS);
   localparam int WIDX_W = $clog2(MAP_WORDS);
   localparam int WCNT_W = $clog2(MAP_WORDS + 1);
   localparam int POS_W  = BIT_W + WIDX_W;

   // Field widths
   localparam int NUM_W      = 17;
   localparam int BASE_W     = 16;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;
   localparam int SUM_W      = ((POS_W > NUM_W) ? POS_W : NUM_W) + 1;

   localparam logic [NUM_W-1:0] LIMIT_RESET = NUM_W'(65536);

   typedef logic [WORD_BITS-1:0]  word_type;
   typedef logic [WIDX_W-1:0]     widx_type;
   typedef logic [WCNT_W-1:0]     wcnt_type;
   typedef logic [BIT_W-1:0]      bit_type;
   typedef logic [NUM_W-1:0]      num_type;
   typedef logic [BASE_W-1:0]     base_type;
   typedef logic [SUM_W-1:0]      sum_type;

   // Request codes
   localparam logic ACTION_ALLOC = 1'b0;
   localparam logic ACTION_FREE  = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_OFFSET  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_NUMBER_LIMIT = CSR_IDX_W'(1);

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_BAD  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ALLOC_COMMIT,
      ST_FREE_CHECK,
      ST_FREE_READ,
      ST_DONE
   } state_type;

   localparam word_type LAST_WORD_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);

   // Bits of a word that belong to the map
   function automatic word_type word_valid(widx_type w);
      word_valid = (w == WIDX_W'(MAP_WORDS - 1)) ? LAST_WORD_MASK : {WORD_BITS{1'b1}};
   endfunction

endpackage

[rtl/bba_if.sv]
// Request and response channel interfaces of the bitmap block allocator.
interface bba_req_if;
   logic                     valid;
   logic                     ready;
   logic                     action;
   logic [bba_pkg::NUM_W-1:0] block_number;

   modport source (output valid, output action, output block_number, input ready);
   modport sink   (input valid, input action, input block_number, output ready);
endinterface

interface bba_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bba_pkg::NUM_W-1:0]    granted_number;
   logic [bba_pkg::STATUS_W-1:0] status;

   modport source (output valid, output granted_number, output status, input ready);
   modport sink   (input valid, input granted_number, input status, output ready);
endinterface

[rtl/bba_find.sv]
// Lowest set bit search over one bitmap word.
module bba_find (
   input  bba_pkg::word_type free_bits,
   output logic              found,
   output bba_pkg::bit_type  index
);

   // Scan from the top so the lowest set bit wins
   always_comb begin
      found = |free_bits;
      index = '0;
      for (int i = bba_pkg::WORD_BITS - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            index = bba_pkg::BIT_W'(i);
         end
      end
   end

endmodule

[rtl/bitmap_block_allocator.sv]
// Top level of the first-fit bitmap block allocator.
//
// The used/free bitmap lives in one 2048 x 32 synchronous RAM with a single read
// and a single write port. An allocate request scans the RAM one word per cycle
// from word zero and takes the lowest clear bit, or reports the map full. A free
// request is range-checked, then reads its word and clears the bit; a number
// rejected by the range check skips the read. One request is in work at a time;
// the response register lets the next request transfer while an earlier response
// still waits. Reset takes effect at once: a high-water mark records how many
// words have ever been written, and words at or above it read as clear, so the
// RAM needs no clearing pass. Write base_offset and number_limit only while no
// request is in work.
module bitmap_block_allocator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [bba_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bba_pkg::CSR_DATA_W-1:0]   csr_wdata,
   bba_req_if.sink                          req_ch,
   bba_rsp_if.source                        rsp_ch
);

   // Bitmap storage
   bba_pkg::word_type bitmap_mem [bba_pkg::MAP_WORDS];
   bba_pkg::word_type rdata_ff;
   logic              mem_re;
   logic              mem_we;
   bba_pkg::widx_type mem_raddr;
   bba_pkg::widx_type mem_waddr;
   bba_pkg::word_type mem_wdata;

   // Control state
   bba_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rvalid_ff, rvalid_in;
   bba_pkg::wcnt_type  hwm_ff, hwm_in;
   bba_pkg::base_type  base_offset_ff, base_offset_in;
   bba_pkg::num_type   number_limit_ff, number_limit_in;

   // Payload
   bba_pkg::wcnt_type   issue_ff, issue_in;
   bba_pkg::widx_type   rword_ff, rword_in;
   bba_pkg::widx_type   fword_ff, fword_in;
   bba_pkg::bit_type    fbit_ff, fbit_in;
   bba_pkg::word_type   fdata_ff, fdata_in;
   bba_pkg::num_type    number_ff, number_in;
   bba_pkg::num_type    res_number_ff, res_number_in;
   bba_pkg::status_type res_status_ff, res_status_in;
   bba_pkg::num_type    rsp_number_ff, rsp_number_in;
   bba_pkg::status_type rsp_status_ff, rsp_status_in;

   // Decode
   logic              req_fire;
   logic              out_free;
   logic              issue_done;
   logic              rword_cold;
   bba_pkg::word_type scan_word;
   bba_pkg::word_type scan_free;
   logic              scan_found;
   bba_pkg::bit_type  scan_bit;
   logic              scan_last;
   bba_pkg::sum_type  alloc_sum;
   logic              alloc_over;
   bba_pkg::sum_type  free_pos;
   logic              free_bad;
   bba_pkg::widx_type free_word;
   bba_pkg::bit_type  free_bit;
   logic              fword_cold;
   bba_pkg::word_type free_data;
   logic              free_set;

   // Handshake
   assign req_ch.ready          = (state_ff == bba_pkg::ST_IDLE);
   assign req_fire              = req_ch.valid && req_ch.ready;
   assign out_free              = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.granted_number = rsp_number_ff;
   assign rsp_ch.status         = rsp_status_ff;

   // Scan: words at or above the high-water mark were never written and are clear
   assign issue_done = (issue_ff == bba_pkg::WCNT_W'(bba_pkg::MAP_WORDS));
   assign rword_cold = ({1'b0, rword_ff} >= hwm_ff);
   assign scan_word  = rword_cold ? '0 : rdata_ff;
   assign scan_free  = ~scan_word & bba_pkg::word_valid(rword_ff);
   assign scan_last  = (rword_ff == bba_pkg::WIDX_W'(bba_pkg::MAP_WORDS - 1));

   bba_find u_find (
      .free_bits (scan_free),
      .found     (scan_found),
      .index     (scan_bit)
   );

   // Allocate commit: absolute number against the limit
   assign alloc_sum  = bba_pkg::SUM_W'(base_offset_ff) + bba_pkg::SUM_W'({fword_ff, fbit_ff});
   assign alloc_over = (alloc_sum >= bba_pkg::SUM_W'(number_limit_ff));

   // Free check: range of the given number
   assign free_pos  = bba_pkg::SUM_W'(number_ff) - bba_pkg::SUM_W'(base_offset_ff);
   assign free_bad  = (number_ff < bba_pkg::NUM_W'(base_offset_ff)) ||
                      (number_ff >= number_limit_ff) ||
                      (free_pos >= bba_pkg::SUM_W'(bba_pkg::TOTAL_BITS));
   assign free_word = free_pos[bba_pkg::BIT_W +: bba_pkg::WIDX_W];
   assign free_bit  = free_pos[bba_pkg::BIT_W-1:0];

   // Free read: test the bit
   assign fword_cold = ({1'b0, fword_ff} >= hwm_ff);
   assign free_data  = fword_cold ? '0 : rdata_ff;
   assign free_set   = free_data[fbit_ff];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bba_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_ch.action == bba_pkg::ACTION_ALLOC) ?
                          bba_pkg::ST_SCAN : bba_pkg::ST_FREE_CHECK;
            end
         end
         bba_pkg::ST_SCAN: begin
            if (rvalid_ff && scan_found) begin
               state_in = bba_pkg::ST_ALLOC_COMMIT;
            end else if (rvalid_ff && scan_last) begin
               state_in = bba_pkg::ST_DONE;
            end
         end
         bba_pkg::ST_ALLOC_COMMIT: begin
            state_in = bba_pkg::ST_DONE;
         end
         bba_pkg::ST_FREE_CHECK: begin
            state_in = free_bad ? bba_pkg::ST_DONE : bba_pkg::ST_FREE_READ;
         end
         bba_pkg::ST_FREE_READ: begin
            state_in = bba_pkg::ST_DONE;
         end
         bba_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = bba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bba_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and memory control
   always_comb begin
      mem_re        = 1'b0;
      mem_raddr     = issue_ff[bba_pkg::WIDX_W-1:0];
      mem_we        = 1'b0;
      mem_waddr     = fword_ff;
      mem_wdata     = fdata_ff | (bba_pkg::WORD_BITS'(1) << fbit_ff);
      rvalid_in     = 1'b0;
      issue_in      = issue_ff;
      rword_in      = rword_ff;
      fword_in      = fword_ff;
      fbit_in       = fbit_ff;
      fdata_in      = fdata_ff;
      number_in     = number_ff;
      hwm_in        = hwm_ff;
      res_number_in = res_number_ff;
      res_status_in = res_status_ff;
      rsp_number_in = rsp_number_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;

      case (state_ff)
         bba_pkg::ST_IDLE: begin
            // Capture the request, restart the scan pipeline
            if (req_fire) begin
               number_in = req_ch.block_number;
               issue_in  = '0;
            end
         end
         bba_pkg::ST_SCAN: begin
            // Issue one word a cycle, check the word read last cycle
            mem_re    = !issue_done;
            rvalid_in = !issue_done;
            if (!issue_done) begin
               issue_in = issue_ff + bba_pkg::WCNT_W'(1);
               rword_in = issue_ff[bba_pkg::WIDX_W-1:0];
            end
            if (rvalid_ff && scan_found) begin
               fword_in = rword_ff;
               fbit_in  = scan_bit;
               fdata_in = scan_word;
            end else if (rvalid_ff && scan_last) begin
               res_number_in = '0;
               res_status_in = bba_pkg::STATUS_FULL;
            end
         end
         bba_pkg::ST_ALLOC_COMMIT: begin
            // Set the bit unless the number reaches the limit
            if (alloc_over) begin
               res_number_in = '0;
               res_status_in = bba_pkg::STATUS_FULL;
            end else begin
               mem_we        = 1'b1;
               res_number_in = alloc_sum[bba_pkg::NUM_W-1:0];
               res_status_in = bba_pkg::STATUS_OK;
               if ({1'b0, fword_ff} == hwm_ff) begin
                  hwm_in = hwm_ff + bba_pkg::WCNT_W'(1);
               end
            end
         end
         bba_pkg::ST_FREE_CHECK: begin
            res_number_in = '0;
            res_status_in = bba_pkg::STATUS_BAD;
            if (!free_bad) begin
               mem_re    = 1'b1;
               mem_raddr = free_word;
               fword_in  = free_word;
               fbit_in   = free_bit;
            end
         end
         bba_pkg::ST_FREE_READ: begin
            // Clear the bit if it was set
            mem_wdata = free_data & ~(bba_pkg::WORD_BITS'(1) << fbit_ff);
            if (free_set) begin
               mem_we        = 1'b1;
               res_status_in = bba_pkg::STATUS_OK;
            end
         end
         bba_pkg::ST_DONE: begin
            // Load the response register once it is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_number_in = res_number_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Configuration writes
   always_comb begin
      base_offset_in  = base_offset_ff;
      number_limit_in = number_limit_ff;
      if (csr_we && (csr_index == bba_pkg::CSR_BASE_OFFSET)) begin
         base_offset_in = csr_wdata[bba_pkg::BASE_W-1:0];
      end
      if (csr_we && (csr_index == bba_pkg::CSR_NUMBER_LIMIT)) begin
         number_limit_in = csr_wdata[bba_pkg::NUM_W-1:0];
      end
   end

   // Bitmap RAM
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= bitmap_mem[mem_raddr];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= bba_pkg::ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         rvalid_ff       <= 1'b0;
         hwm_ff          <= '0;
         base_offset_ff  <= '0;
         number_limit_ff <= bba_pkg::LIMIT_RESET;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         rvalid_ff       <= rvalid_in;
         hwm_ff          <= hwm_in;
         base_offset_ff  <= base_offset_in;
         number_limit_ff <= number_limit_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      issue_ff      <= issue_in;
      rword_ff      <= rword_in;
      fword_ff      <= fword_in;
      fbit_ff       <= fbit_in;
      fdata_ff      <= fdata_in;
      number_ff     <= number_in;
      res_number_ff <= res_number_in;
      res_status_ff <= res_status_in;
      rsp_number_ff <= rsp_number_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

[verif/tb_bitmap_block_allocator.sv]
// Self-checking testbench for the first-fit bitmap block allocator.
`timescale 1ns / 100ps

// Shadow copy of the usage bitmap and registers; predicts each grant in order
class bitmap_shadow;
   typedef struct packed {
      bba_pkg::num_type    number;
      bba_pkg::status_type status;
   } grant_type;

   bit                  in_use [bba_pkg::TOTAL_BITS];
   int unsigned         held_q [$];
   bba_pkg::base_type   base;
   bba_pkg::num_type    limit;
   grant_type           grant_q [$];
   int unsigned         mismatches;
   int unsigned         grants;
   int unsigned         refusals;
   int unsigned         rejects;

   function new();
      base  = '0;
      limit = bba_pkg::LIMIT_RESET;
   endfunction

   // Mirror a register write; unused indexes change nothing
   function void set_reg(logic [bba_pkg::CSR_IDX_W-1:0] reg_index,
                         logic [bba_pkg::CSR_DATA_W-1:0] value);
      case (reg_index)
         bba_pkg::CSR_BASE_OFFSET:  base  = value[bba_pkg::BASE_W-1:0];
         bba_pkg::CSR_NUMBER_LIMIT: limit = value[bba_pkg::NUM_W-1:0];
         default: ;
      endcase
   endfunction

   // Predict the grant for one request transfer and update the shadow map
   function void note_request(logic action, bba_pkg::num_type number);
      grant_type   g;
      int unsigned pos;
      int          hit [$];
      g.number = '0;
      g.status = bba_pkg::STATUS_BAD;
      if (action == bba_pkg::ACTION_ALLOC) begin
         pos = 0;
         while (pos < bba_pkg::TOTAL_BITS && in_use[pos])
            pos++;
         g.status = bba_pkg::STATUS_FULL;
         if (pos < bba_pkg::TOTAL_BITS && base + pos < limit) begin
            in_use[pos] = 1'b1;
            held_q.push_back(pos);
            g.number = bba_pkg::num_type'(base + pos);
            g.status = bba_pkg::STATUS_OK;
         end
      end else if (number >= base && number < limit &&
                   number - base < bba_pkg::TOTAL_BITS) begin
         pos = number - base;
         if (in_use[pos]) begin
            in_use[pos] = 1'b0;
            hit = held_q.find_first_index(p) with (p == pos);
            held_q.delete(hit[0]);
            g.status = bba_pkg::STATUS_OK;
         end
      end
      grant_q.push_back(g);
   endfunction

   // Absolute number of a random block that is currently in use, or the base if none is
   function bba_pkg::num_type held_number();
      if (held_q.size() == 0)
         return bba_pkg::num_type'(base);
      return bba_pkg::num_type'(base + held_q[$urandom_range(0, held_q.size() - 1)]);
   endfunction

   task report(string msg);
      $display("%0t ns  MISMATCH  %s", $time, msg);
      mismatches++;
   endtask

   // Compare one response transfer with the oldest predicted grant
   task check_grant(bba_pkg::num_type number, logic [bba_pkg::STATUS_W-1:0] status);
      grant_type g;
      if (grant_q.size() == 0) begin
         report($sformatf("response with nothing pending: number %0d status %0d",
                          number, status));
      end else begin
         g = grant_q.pop_front();
         if (status !== g.status)
            report($sformatf("status %0d, predicted %s", status, g.status.name()));
         if (number !== g.number)
            report($sformatf("granted number %0d, predicted %0d", number, g.number));
         case (g.status)
            bba_pkg::STATUS_OK:   grants++;
            bba_pkg::STATUS_FULL: refusals++;
            default:              rejects++;
         endcase
      end
   endtask
endclass

module tb_bitmap_block_allocator;

   // Register indexes that decode to nothing
   localparam logic [bba_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = bba_pkg::CSR_IDX_W'(2);
   localparam logic [bba_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = bba_pkg::CSR_IDX_W'(3);

   logic                           clock;
   logic                           reset;
   logic                           csr_we;
   logic [bba_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [bba_pkg::CSR_DATA_W-1:0] csr_wdata;
   bit                             quiet;
   int unsigned                    settings;

   bitmap_shadow shadow = new();

   bba_req_if req_ch ();
   bba_rsp_if rsp_ch ();

   bitmap_block_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stop a hung run
   initial begin
      #50ms;
      $display("Timeout with %0d responses outstanding", shadow.grant_q.size());
      $display("Mismatches found");
      $finish;
   end

   // Predict on every request transfer
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         shadow.note_request(req_ch.action, req_ch.block_number);
   end

   // Check every response transfer
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         shadow.check_grant(rsp_ch.granted_number, rsp_ch.status);
   end

   // Stall the response side in random bursts
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left != 0)
            stall_left--;
         else if (!quiet && $urandom_range(0, 99) < 12)
            stall_left = $urandom_range(1, 10);
         rsp_ch.ready <= (stall_left == 0);
      end
   end

   // Hold one request until it transfers; call right after a falling edge
   task automatic drive_item(logic action, bba_pkg::num_type number);
      req_ch.valid        <= 1'b1;
      req_ch.action       <= action;
      req_ch.block_number <= number;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   task automatic send(logic action, bba_pkg::num_type number);
      @(negedge clock);
      drive_item(action, number);
   endtask

   // Drop valid for a burst of cycles
   task automatic hold_off(int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
   endtask

   // Drop valid and wait for every predicted response
   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (shadow.grant_q.size() != 0)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_reg(logic [bba_pkg::CSR_IDX_W-1:0] reg_index,
                            logic [bba_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= reg_index;
      csr_wdata <= value;
      shadow.set_reg(reg_index, value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_regs(logic [bba_pkg::CSR_DATA_W-1:0] base_val,
                            logic [bba_pkg::CSR_DATA_W-1:0] limit_val);
      wait_drained();
      write_reg(bba_pkg::CSR_BASE_OFFSET, base_val);
      write_reg(bba_pkg::CSR_NUMBER_LIMIT, limit_val);
      settings++;
   endtask

   initial begin
      int unsigned                    phase;
      int unsigned                    count;
      int unsigned                    roll;
      logic [bba_pkg::CSR_DATA_W-1:0] base_val;
      logic [bba_pkg::CSR_DATA_W-1:0] limit_val;
      logic                           act;
      bba_pkg::num_type               num;

      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = bba_pkg::CSR_BASE_OFFSET;
      csr_wdata           = '0;
      req_ch.valid        = 1'b0;
      req_ch.action       = bba_pkg::ACTION_ALLOC;
      req_ch.block_number = '0;
      settings            = 1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset register values: first fits, double free, range edges
      send(bba_pkg::ACTION_ALLOC, '0);
      send(bba_pkg::ACTION_ALLOC, '1);
      send(bba_pkg::ACTION_ALLOC, '0);
      send(bba_pkg::ACTION_FREE, bba_pkg::num_type'(1));
      send(bba_pkg::ACTION_FREE, bba_pkg::num_type'(1));
      send(bba_pkg::ACTION_ALLOC, '0);
      send(bba_pkg::ACTION_FREE, bba_pkg::num_type'(65535));
      send(bba_pkg::ACTION_FREE, bba_pkg::num_type'(65536));
      send(bba_pkg::ACTION_FREE, '1);
      send(bba_pkg::ACTION_FREE, '0);
      send(bba_pkg::ACTION_ALLOC, '0);

      // Top base (upper data bit dropped), top limit, writes to unused indexes
      load_regs('1, '1);
      write_reg(CSR_SPARE_LO, '0);
      write_reg(CSR_SPARE_HI, '0);
      send(bba_pkg::ACTION_ALLOC, '0);
      send(bba_pkg::ACTION_FREE, bba_pkg::num_type'(65534));
      send(bba_pkg::ACTION_FREE, bba_pkg::num_type'(65535));
      send(bba_pkg::ACTION_FREE, bba_pkg::num_type'(131070));

      // Free beyond the end of the map while below the limit
      load_regs('0, '1);
      send(bba_pkg::ACTION_FREE, bba_pkg::num_type'(65536));
      send(bba_pkg::ACTION_FREE, bba_pkg::num_type'(100000));

      // Zero limit: nothing can be granted or freed
      load_regs('0, '0);
      send(bba_pkg::ACTION_ALLOC, '0);
      send(bba_pkg::ACTION_FREE, bba_pkg::num_type'(1));

      // Small window: allocate until the limit refuses
      load_regs(bba_pkg::CSR_DATA_W'(10), bba_pkg::CSR_DATA_W'(15));
      repeat (5) send(bba_pkg::ACTION_ALLOC, '0);

      // Random phases, each under its own register setting
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               base_val  = '0;
               limit_val = bba_pkg::LIMIT_RESET;
               count     = 60;
            end
            1: begin
               base_val  = bba_pkg::CSR_DATA_W'(16'hFFFF);
               limit_val = '1;
               count     = 50;
            end
            2: begin
               base_val  = bba_pkg::CSR_DATA_W'($urandom_range(0, 65535));
               limit_val = base_val + bba_pkg::CSR_DATA_W'($urandom_range(8, 64));
               count     = 50;
            end
            3: begin
               base_val  = bba_pkg::CSR_DATA_W'($urandom_range(0, 1000));
               limit_val = bba_pkg::CSR_DATA_W'($urandom);
               count     = 40;
            end
            4: begin base_val = '0; limit_val = '0; count = 15; end
            default: begin
               base_val  = bba_pkg::CSR_DATA_W'(17);
               limit_val = '1;
               count     = 50;
            end
         endcase
         load_regs(base_val, limit_val);
         quiet = (phase == 5);
         for (int i = 0; i < count; i++) begin
            if (phase == 0 && i == 30)
               wait_drained();
            if (!quiet && $urandom_range(0, 99) < 20)
               hold_off($urandom_range(1, 10));
            @(negedge clock);
            // Mostly allocations and frees of held blocks, some stray numbers
            roll = $urandom_range(0, 99);
            act  = bba_pkg::ACTION_FREE;
            num  = shadow.held_number();
            if (roll < 45) begin
               act = bba_pkg::ACTION_ALLOC;
               num = bba_pkg::num_type'($urandom);
            end else if (roll < 80) begin
               act = bba_pkg::ACTION_FREE;
            end else if (roll < 88) begin
               num = bba_pkg::num_type'($urandom);
            end else if (roll < 94) begin
               num = bba_pkg::num_type'(shadow.base + $urandom_range(0, 400));
            end else if (roll < 97) begin
               num = shadow.limit;
            end else begin
               num = bba_pkg::num_type'(shadow.base) - 1'b1;
            end
            drive_item(act, num);
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (shadow.grant_q.size() != 0)
         shadow.report($sformatf("%0d responses never arrived", shadow.grant_q.size()));

      $display("Ran %0d requests over %0d register settings, reset values and extremes included.",
               shadow.grants + shadow.refusals + shadow.rejects, settings);
      $display("Outcomes: %0d grants or frees, %0d refused allocations, %0d rejected frees.",
               shadow.grants, shadow.refusals, shadow.rejects);
      if (shadow.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

[filelist.f]
rtl/bba_pkg.sv
rtl/bba_if.sv
rtl/bba_find.sv
rtl/bitmap_block_allocator.sv
verif/tb_bitmap_block_allocator.sv
